>>> rtl/stq_pkg.sv
`default_nettype none
package stq_pkg;

  localparam int DATA_W = 32;
  localparam int POS_W  = 10;
  localparam int END_W  = 11;

  typedef enum logic [1:0] {
    MODE_MIN = 2'd0,
    MODE_MAX = 2'd1,
    MODE_SUM = 2'd2,
    MODE_RSV = 2'd3
  } mode_t;

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_QUERY  = 1'b1
  } op_t;

  localparam logic REG_MODE = 1'b0;
  localparam logic REG_KIND = 1'b1;

  typedef struct packed {
    op_t               op;
    logic [END_W-1:0]  lo;
    logic [END_W-1:0]  hi;
    logic [DATA_W-1:0] value;
  } cmd_t;

  function automatic logic [DATA_W-1:0] ident_of(input mode_t m);
    logic [DATA_W-1:0] r;
    unique case (m)
      MODE_MIN: r = 32'h7FFF_FFFF;
      MODE_MAX: r = 32'h8000_0000;
      default:  r = 32'h0;
    endcase
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] fold2(input mode_t m, input logic [DATA_W-1:0] a,
                                              input logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] r;
    unique case (m)
      MODE_MIN: r = ($signed(a) <= $signed(b)) ? a : b;
      MODE_MAX: r = ($signed(a) >= $signed(b)) ? a : b;
      default:  r = a + b;
    endcase
    return r;
  endfunction

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LEAF_RD,
    ST_UP_RD,
    ST_UP_WR,
    ST_Q_RD,
    ST_Q_ACC,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

>>> rtl/stq_front.sv
`default_nettype none
module stq_front
  import stq_pkg::*;
#(
  parameter int LEAVES = 1024,
  parameter int DEPTH  = 2
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire               operation,
  input  wire  [POS_W-1:0]  position,
  input  wire  [END_W-1:0]  range_end,
  input  wire  [DATA_W-1:0] value,
  input  wire               flush,
  output logic              q_valid,
  input  wire               q_ready,
  output cmd_t              q_cmd
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [END_W:0] LV = (END_W + 1)'(LEAVES);

  cmd_t           fifo [DEPTH];
  logic [AW-1:0]  wp, rp;
  logic [AW:0]    count;
  logic           push, pop, keep;
  cmd_t           c;
  logic [END_W:0] pe, ee;

  always_comb begin
    pe = {1'b0, END_W'(position)};
    ee = {1'b0, range_end};
    c.op    = op_t'(operation);
    c.value = value;
    c.lo    = (pe > LV) ? END_W'(LV) : END_W'(pe);
    c.hi    = (ee > LV) ? END_W'(LV) : END_W'(ee);
    // updates past the last leaf are dropped here, empty queries pass to the back part
    keep = (operation == OP_QUERY) || (pe < LV);
  end

  assign in_ready = (count != (AW + 1)'(DEPTH)) && !flush;
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (count != '0);
  assign pop      = q_valid && q_ready;
  assign q_cmd    = fifo[rp];

  always_ff @(posedge clk) begin
    if (push) fifo[wp] <= c;
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (push) wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      if (pop)  rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      count <= count + (AW + 1)'(push) - (AW + 1)'(pop);
    end
  end

  a_no_over: assert property (@(posedge clk) disable iff (rst)
    count == (AW + 1)'(DEPTH) |-> !push) else $error("queue overflow");
  a_no_under: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> !pop) else $error("queue underflow");
  a_count: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1) else $error("count slip");

endmodule
`default_nettype wire

>>> rtl/stq_back.sv
`default_nettype none
module stq_back
  import stq_pkg::*;
#(
  parameter int LEAVES = 1024
) (
  input  wire               clk,
  input  wire               rst,
  input  mode_t             mode,
  input  wire               kind,
  input  wire               clear_req,
  input  wire               q_valid,
  output logic              q_ready,
  input  cmd_t              q_cmd,
  output logic              out_valid,
  input  wire               out_ready,
  output logic [DATA_W-1:0] answer
);

  localparam int LW = $clog2(LEAVES);
  localparam int NW = LW + 1;
  localparam int NODES = 2 * LEAVES;

  logic [DATA_W-1:0] mem [NODES];
  logic [DATA_W-1:0] rdata;
  logic [NW-1:0]     raddr, waddr;
  logic [DATA_W-1:0] wdata;
  logic              we;

  state_t state, state_next;
  logic [NW:0]       l, l_next, r, r_next;
  logic [NW-1:0]     idx, idx_next;
  logic [DATA_W-1:0] acc_l, acc_l_next, acc_r, acc_r_next;
  logic [DATA_W-1:0] val, val_next;
  logic              side, side_next, updk, updk_next;
  logic [DATA_W-1:0] res, res_next;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_comb begin
    state_next = state;
    l_next = l; r_next = r; idx_next = idx;
    acc_l_next = acc_l; acc_r_next = acc_r;
    val_next = val; side_next = side; updk_next = updk;
    res_next = res;
    raddr = '0; waddr = idx; wdata = ident_of(mode); we = 1'b0;
    q_ready = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        we = 1'b1;
        idx_next = idx + 1'b1;
        if (idx == NW'(NODES - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          val_next = q_cmd.value;
          updk_next = kind;
          if (q_cmd.op == OP_UPDATE) begin
            idx_next = NW'(q_cmd.lo) + NW'(LEAVES);
            raddr = NW'(q_cmd.lo) + NW'(LEAVES);
            state_next = ST_LEAF_RD;
          end else begin
            l_next = (NW + 1)'(q_cmd.lo) + (NW + 1)'(LEAVES);
            r_next = (NW + 1)'(q_cmd.hi) + (NW + 1)'(LEAVES);
            acc_l_next = ident_of(mode);
            acc_r_next = ident_of(mode);
            state_next = ST_Q_RD;
          end
        end
      end
      ST_LEAF_RD: begin
        waddr = idx;
        wdata = updk ? rdata + val : val;
        we = 1'b1;
        val_next = wdata;
        raddr = idx ^ NW'(1);
        state_next = ST_UP_RD;
      end
      ST_UP_RD: begin
        // val holds the node just written, rdata its sibling
        res_next = idx[0] ? fold2(mode, rdata, val) : fold2(mode, val, rdata);
        idx_next = idx >> 1;
        state_next = ST_UP_WR;
      end
      ST_UP_WR: begin
        waddr = idx;
        wdata = res;
        we = 1'b1;
        val_next = res;
        raddr = idx ^ NW'(1);
        if (idx == NW'(1)) state_next = ST_IDLE;
        else state_next = ST_UP_RD;
      end
      ST_Q_RD: begin
        if (l >= r) begin
          res_next = fold2(mode, acc_l, acc_r);
          state_next = ST_OUT;
        end else if (l[0]) begin
          raddr = NW'(l);
          side_next = 1'b0;
          l_next = l + 1'b1;
          state_next = ST_Q_ACC;
        end else if (r[0]) begin
          raddr = NW'(r - 1'b1);
          side_next = 1'b1;
          r_next = r - 1'b1;
          state_next = ST_Q_ACC;
        end else begin
          l_next = l >> 1;
          r_next = r >> 1;
        end
      end
      ST_Q_ACC: begin
        if (side) acc_r_next = fold2(mode, rdata, acc_r);
        else      acc_l_next = fold2(mode, acc_l, rdata);
        state_next = ST_Q_RD;
      end
      ST_OUT: begin
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
    if (clear_req) begin
      state_next = ST_CLEAR;
      idx_next = '0;
    end
  end

  assign out_valid = (state == ST_OUT);
  assign answer = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      idx <= '0;
    end else begin
      state <= state_next;
      idx <= idx_next;
    end
    l <= l_next; r <= r_next;
    acc_l <= acc_l_next; acc_r <= acc_r_next;
    val <= val_next; side <= side_next; updk <= updk_next;
    res <= res_next;
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && !clear_req |=> out_valid && $stable(answer))
    else $error("result dropped");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !q_ready) else $error("accept while busy");
  a_clr: assert property (@(posedge clk) disable iff (rst)
    clear_req |=> state == ST_CLEAR) else $error("clear not started");

endmodule
`default_nettype wire

>>> rtl/segment_tree_range_query.sv
// query: climbs the tree, reading each needed node in ST_Q_RD and folding it in ST_Q_ACC
// update: writes the leaf, then recomputes each ancestor up to the root
// a front queue of two items takes input while the back part works on one item at a time
// reset, and every write of combine_mode, run a clearing pass over all 2*LEAVES nodes
// during the pass no item leaves the queue; registers reset to zero
`default_nettype none
module segment_tree_range_query
  import stq_pkg::*;
#(
  parameter int LEAVES = 1024
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire  [2:0]        paddr,
  input  wire  [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire               operation,
  input  wire  [POS_W-1:0]  position,
  input  wire  [END_W-1:0]  range_end,
  input  wire  [DATA_W-1:0] value,
  output logic              out_valid,
  input  wire               out_ready,
  output logic [DATA_W-1:0] answer
);

  mode_t mode;
  logic  kind, wr, clr;
  logic  q_valid, q_ready;
  cmd_t  q_cmd;

  assign pready = 1'b1;
  assign wr  = psel && penable && pwrite;
  assign clr = wr && (paddr[2] == REG_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_MIN;
      kind <= 1'b0;
    end else if (wr) begin
      if (paddr[2] == REG_MODE) mode <= mode_t'(pwdata[1:0]);
      if (paddr[2] == REG_KIND) kind <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MODE) prdata = {30'b0, mode};
    else if (paddr[2] == REG_KIND) prdata = {31'b0, kind};
  end

  stq_front #(.LEAVES(LEAVES), .DEPTH(2)) u_front (
    .clk, .rst, .in_valid, .in_ready, .operation, .position, .range_end, .value,
    .flush(1'b0), .q_valid, .q_ready, .q_cmd
  );

  stq_back #(.LEAVES(LEAVES)) u_back (
    .clk, .rst, .mode, .kind, .clear_req(clr), .q_valid, .q_ready, .q_cmd,
    .out_valid, .out_ready, .answer
  );

endmodule
`default_nettype wire

>>> verif/tb_segment_tree_range_query.sv
`default_nettype none
module tb_segment_tree_range_query;
  import stq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NLEAF = 1024;
  localparam int CYCLE_LIMIT = 900000;
  localparam int SETTLE = 160;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic operation = 1'b0;
  logic [POS_W-1:0] position = '0;
  logic [END_W-1:0] range_end = '0;
  logic [DATA_W-1:0] value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [DATA_W-1:0] answer;

  logic [DATA_W-1:0] tree_model [0:2*NLEAF-1];
  mode_t model_mode;
  logic model_kind;
  logic [DATA_W-1:0] exp_answers [$];
  int mismatches = 0;
  int cycles = 0;
  bit no_idle = 1'b0;
  int stall_left = 0;

  segment_tree_range_query #(.LEAVES(NLEAF)) uut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .operation(operation),
    .position(position), .range_end(range_end), .value(value),
    .out_valid(out_valid), .out_ready(out_ready), .answer(answer)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [DATA_W-1:0] ident_value(mode_t m);
    if (m == MODE_MIN) return 32'h7FFF_FFFF;
    if (m == MODE_MAX) return 32'h8000_0000;
    return 32'h0;
  endfunction

  function automatic logic [DATA_W-1:0] fold_pair(mode_t m, logic [DATA_W-1:0] a,
                                                  logic [DATA_W-1:0] b);
    if (m == MODE_MIN) return ($signed(a) <= $signed(b)) ? a : b;
    if (m == MODE_MAX) return ($signed(a) >= $signed(b)) ? a : b;
    return a + b;
  endfunction

  function automatic logic [DATA_W-1:0] range_fold(int lo, int hi);
    logic [DATA_W-1:0] acc_l;
    logic [DATA_W-1:0] acc_r;
    int l;
    int r;
    acc_l = ident_value(model_mode);
    acc_r = acc_l;
    l = ((lo > NLEAF) ? NLEAF : lo) + NLEAF;
    r = ((hi > NLEAF) ? NLEAF : hi) + NLEAF;
    while (l < r) begin
      if (l % 2 == 1) begin
        acc_l = fold_pair(model_mode, acc_l, tree_model[l]);
        l++;
      end
      if (r % 2 == 1) begin
        r--;
        acc_r = fold_pair(model_mode, tree_model[r], acc_r);
      end
      l = l / 2;
      r = r / 2;
    end
    return fold_pair(model_mode, acc_l, acc_r);
  endfunction

  task automatic apply_update(int pos, logic [DATA_W-1:0] v);
    int i;
    if (pos >= NLEAF) return;
    i = pos + NLEAF;
    tree_model[i] = model_kind ? tree_model[i] + v : v;
    i = i / 2;
    while (i != 0) begin
      tree_model[i] = fold_pair(model_mode, tree_model[2*i], tree_model[2*i+1]);
      i = i / 2;
    end
  endtask

  task automatic clear_model();
    for (int k = 0; k < 2*NLEAF; k++) tree_model[k] = ident_value(model_mode);
  endtask

  // one item; caller is at a rising edge, returns at the accepting edge or after a random idle gap behind it
  task automatic send_item(op_t op, int pos, int hi, logic [DATA_W-1:0] v);
    int gap;
    in_valid <= 1'b1;
    operation <= op;
    position <= pos[POS_W-1:0];
    range_end <= hi[END_W-1:0];
    value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op == OP_UPDATE) apply_update(pos % NLEAF, v);
    else exp_answers.push_back(range_fold(pos % NLEAF, hi % (2*NLEAF)));
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (exp_answers.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == {REG_MODE, 2'b00}) begin
      model_mode = mode_t'(data[1:0]);
      clear_model();
    end else if (addr == {REG_KIND, 2'b00}) begin
      model_kind = data[0];
    end
  endtask

  task automatic configure(int mode, int kind);
    drain();
    reg_write({REG_MODE, 2'b00}, 32'(mode) | ($urandom() & 32'hFFFF_FFFC));
    reg_write({REG_KIND, 2'b00}, 32'(kind) | ($urandom() & 32'hFFFF_FFFE));
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0;
      4: return 32'($urandom_range(0, 40)) - 32'd20;
      default: return $urandom();
    endcase
  endfunction

  function automatic int pick_end(int lo);
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 2047);
      1: return lo;
      2: return (lo > 0) ? $urandom_range(0, lo - 1) : 0;
      3: return NLEAF;
      default: return $urandom_range(lo, NLEAF);
    endcase
  endfunction

  task automatic test_reset_state();
    send_item(OP_QUERY, 0, NLEAF, 32'h0);
    send_item(OP_QUERY, 17, 300, 32'hFFFF_FFFF);
  endtask

  task automatic test_directed();
    configure(MODE_MIN, 0);
    send_item(OP_UPDATE, 0, 2047, 32'h8000_0000);
    send_item(OP_UPDATE, 1023, 0, 32'h7FFF_FFFE);
    send_item(OP_QUERY, 0, NLEAF, 32'h0);
    send_item(OP_QUERY, 1, 2047, 32'h0);
    send_item(OP_QUERY, 1023, 1024, 32'h0);
    send_item(OP_QUERY, 5, 3, 32'h0);
    send_item(OP_QUERY, 9, 9, 32'h0);
    configure(MODE_MAX, 1);
    send_item(OP_UPDATE, 1023, 0, 32'h7FFF_FFFF);
    send_item(OP_UPDATE, 1023, 0, 32'h0000_0001);
    send_item(OP_UPDATE, 512, 0, 32'hFFFF_FFFF);
    send_item(OP_QUERY, 0, 2047, 32'h0);
    send_item(OP_QUERY, 600, 1024, 32'h0);
    configure(MODE_SUM, 1);
    send_item(OP_UPDATE, 3, 0, 32'hFFFF_FFFF);
    send_item(OP_UPDATE, 3, 0, 32'h8000_0000);
    send_item(OP_UPDATE, 4, 0, 32'h7FFF_FFFF);
    send_item(OP_QUERY, 0, NLEAF, 32'h0);
    send_item(OP_QUERY, 1023, 1023, 32'h0);
    configure(MODE_RSV, 0);
    send_item(OP_UPDATE, 7, 0, 32'h0000_0005);
    send_item(OP_UPDATE, 8, 0, 32'hFFFF_FFFD);
    send_item(OP_QUERY, 0, NLEAF, 32'h0);
    send_item(OP_QUERY, 8, 1500, 32'h0);
    // pause the sender until every answer is back
    drain();
    send_item(OP_QUERY, 7, 8, 32'h0);
  endtask

  task automatic random_phase(int mode, int kind, int count);
    int lo;
    configure(mode, kind);
    for (int n = 0; n < count; n++) begin
      lo = $urandom_range(0, NLEAF - 1);
      if ($urandom_range(0, 9) < 6) send_item(OP_UPDATE, lo, $urandom_range(0, 2047),
                                              pick_value());
      else send_item(OP_QUERY, lo, pick_end(lo), $urandom());
    end
  endtask

  task automatic test_random();
    random_phase(MODE_MIN, 0, 230);
    random_phase(MODE_MAX, 0, 230);
    random_phase(MODE_SUM, 1, 230);
    random_phase(MODE_MIN, 1, 230);
    random_phase(MODE_MAX, 1, 230);
    random_phase(MODE_RSV, 1, 200);
    random_phase(MODE_SUM, 0, 230);
  endtask

  task automatic test_tail();
    no_idle = 1'b1;
    random_phase(MODE_MIN, 0, 250);
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 16) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (exp_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected answer %h", answer);
      end else begin
        if (answer !== exp_answers[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("answer mismatch: expected %h actual %h", exp_answers[0], answer);
        end
        void'(exp_answers.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    model_mode = MODE_MIN;
    model_kind = 1'b0;
    clear_model();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_directed();
    test_random();
    test_tail();
    drain();
    if (mismatches == 0 && exp_answers.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
